// ----- rtl/vta_pkg.sv -----
// Package for the vertex transform and bounding box core: types, register indexes, constants.
`default_nettype none
package vta_pkg;

  localparam int NUM_AXES  = 3;
  localparam int COORD_W   = 16;
  localparam int ROW_W     = 64;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int FRAC_SHIFT = 12;
  localparam int CFG_IDX_W = 2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic        [ROW_W-1:0]   row_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Z = 2'd2;

  // Identity matrix, zero translation
  localparam row_t ROW_X_RESET = 64'h0000_0000_0000_1000;
  localparam row_t ROW_Y_RESET = 64'h0000_0000_1000_0000;
  localparam row_t ROW_Z_RESET = 64'h0000_1000_0000_0000;

  // Half an output LSB in Q.20, for round to nearest with ties upward
  localparam acc_t ROUND_BIAS = acc_t'(2048);

  localparam coord_t COORD_MAX = 16'sh7FFF;
  localparam coord_t COORD_MIN = 16'sh8000;

  // Drop the 12 extra fraction bits (floor) and clamp to Q8.8
  function automatic coord_t round_sat(input acc_t acc);
    logic signed [ACC_W-FRAC_SHIFT-1:0] q;
    coord_t                             res;
    q = acc[ACC_W-1:FRAC_SHIFT];
    if (q > (ACC_W - FRAC_SHIFT)'(signed'(COORD_MAX))) begin
      res = COORD_MAX;
    end else if (q < (ACC_W - FRAC_SHIFT)'(signed'(COORD_MIN))) begin
      res = COORD_MIN;
    end else begin
      res = q[COORD_W-1:0];
    end
    return res;
  endfunction

  function automatic acc_t ext_prod(input prod_t p);
    return {{(ACC_W-PROD_W){p[PROD_W-1]}}, p};
  endfunction

  function automatic acc_t ext_trans(input coord_t t);
    return {{(ACC_W-COORD_W-FRAC_SHIFT){t[COORD_W-1]}}, t, {FRAC_SHIFT{1'b0}}};
  endfunction

endpackage
`default_nettype wire

// ----- rtl/vertex_transform_aabb_core.sv -----
// Affine vertex transform with running axis-aligned bounding box, top level.
//
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------------
//  in      | in_valid / in_stall    | coord_x, coord_y, coord_z, last_vertex
//  out     | out_valid / out_stall  | out_x/y/z, min_x/y/z, max_x/y/z, box_done
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One request per cycle sustained while out is not stalled; an accepted request passes
// through the stage-1 register and then the output register, where out_valid rises.
// The first register holds the nine products; the second holds the summed, rounded,
// saturated vertex and the updated box. The box register loop is one compare stage.
// Reset (rst, synchronous) empties the pipeline, empties the box and loads identity rows.
// A stall on out holds both stages; in_stall rises only when both stages hold requests
// and out is stalled.
`default_nettype none
module vertex_transform_aabb_core (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire vta_pkg::coord_t              coord_x,
  input  wire vta_pkg::coord_t              coord_y,
  input  wire vta_pkg::coord_t              coord_z,
  input  wire                               last_vertex,
  output logic                              out_valid,
  input  wire                               out_stall,
  output vta_pkg::coord_t                   out_x,
  output vta_pkg::coord_t                   out_y,
  output vta_pkg::coord_t                   out_z,
  output vta_pkg::coord_t                   min_x,
  output vta_pkg::coord_t                   min_y,
  output vta_pkg::coord_t                   min_z,
  output vta_pkg::coord_t                   max_x,
  output vta_pkg::coord_t                   max_y,
  output vta_pkg::coord_t                   max_z,
  output logic                              box_done,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [vta_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire vta_pkg::row_t                cfg_data
);
  import vta_pkg::*;

  row_t   row [NUM_AXES];

  logic   s1_valid;
  logic   s1_last;
  prod_t  s1_prod [NUM_AXES][NUM_AXES];

  coord_t box_low  [NUM_AXES];
  coord_t box_high [NUM_AXES];
  logic   box_empty;

  coord_t vtx      [NUM_AXES];
  coord_t low_next [NUM_AXES];
  coord_t high_next[NUM_AXES];
  acc_t   acc      [NUM_AXES];

  logic   out_load;
  logic   s1_load;
  logic   s1_move;

  coord_t coord [NUM_AXES];

  assign coord[0] = coord_x;
  assign coord[1] = coord_y;
  assign coord[2] = coord_z;

  assign out_load  = !out_valid || !out_stall;
  assign s1_move   = s1_valid && out_load;
  assign in_stall  = s1_valid && !out_load;
  assign s1_load   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row[0] <= ROW_X_RESET;
      row[1] <= ROW_Y_RESET;
      row[2] <= ROW_Z_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROW_X: row[0] <= cfg_data;
        REG_ROW_Y: row[1] <= cfg_data;
        REG_ROW_Z: row[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: products of coefficients and coordinates
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_last <= last_vertex;
      for (int r = 0; r < NUM_AXES; r++) begin
        for (int c = 0; c < NUM_AXES; c++) begin
          s1_prod[r][c] <= prod_t'(signed'(row[r][c*COORD_W +: COORD_W]))
                         * prod_t'(coord[c]);
        end
      end
    end
  end

  // Stage 2: sum, round, saturate, fold into the box
  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      acc[r] = ext_prod(s1_prod[r][0]) + ext_prod(s1_prod[r][1]) + ext_prod(s1_prod[r][2])
             + ext_trans(row[r][NUM_AXES*COORD_W +: COORD_W]) + ROUND_BIAS;
      vtx[r] = round_sat(acc[r]);
      if (box_empty) begin
        low_next[r]  = vtx[r];
        high_next[r] = vtx[r];
      end else begin
        low_next[r]  = (vtx[r] < box_low[r])  ? vtx[r] : box_low[r];
        high_next[r] = (vtx[r] > box_high[r]) ? vtx[r] : box_high[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box_empty <= 1'b1;
      for (int r = 0; r < NUM_AXES; r++) begin
        box_low[r]  <= '0;
        box_high[r] <= '0;
      end
    end else if (s1_move) begin
      // clear after the last vertex of an object
      box_empty <= s1_last;
      for (int r = 0; r < NUM_AXES; r++) begin
        box_low[r]  <= s1_last ? '0 : low_next[r];
        box_high[r] <= s1_last ? '0 : high_next[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_x    <= vtx[0];
      out_y    <= vtx[1];
      out_z    <= vtx[2];
      min_x    <= low_next[0];
      min_y    <= low_next[1];
      min_z    <= low_next[2];
      max_x    <= high_next[0];
      max_y    <= high_next[1];
      max_z    <= high_next[2];
      box_done <= s1_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (min_x <= max_x) && (min_y <= max_y) && (min_z <= max_z))
    else $error("box minimum above maximum");

  a_vertex_in_box: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_x >= min_x) && (out_x <= max_x) && (out_y >= min_y)
                  && (out_y <= max_y) && (out_z >= min_z) && (out_z <= max_z))
    else $error("vertex outside its box");

  a_s1_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && in_stall |=> s1_valid)
    else $error("stage 1 request lost under stall");

  a_box_cleared: assert property (@(posedge clk) disable iff (rst)
    s1_move && s1_last |=> box_empty)
    else $error("box not cleared after last vertex");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/tb_vertex_transform_aabb_core.sv -----
// Self-checking testbench for the affine vertex transform and bounding box core.
`timescale 1ns / 100ps
module tb_vertex_transform_aabb_core;
  import vta_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   is_last;
  } vertex_t;

  typedef struct packed {
    coord_t ox, oy, oz;
    coord_t lx, ly, lz;
    coord_t hx, hy, hz;
    logic   done;
  } box_result_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_stall;
  coord_t coord_x = '0;
  coord_t coord_y = '0;
  coord_t coord_z = '0;
  logic   last_vertex = 1'b0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  coord_t out_x, out_y, out_z;
  coord_t min_x, min_y, min_z;
  coord_t max_x, max_y, max_z;
  logic   box_done;
  logic   cfg_valid = 1'b0;
  logic   cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  row_t   cfg_data = '0;

  vertex_transform_aabb_core uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  vertex_t     vertex_q[$];
  box_result_t xform_q[$];

  // Shadow of the matrix rows and the running box
  row_t   mdl_rows[3] = '{ROW_X_RESET, ROW_Y_RESET, ROW_Z_RESET};
  coord_t box_lo[3] = '{0, 0, 0};
  coord_t box_hi[3] = '{0, 0, 0};
  bit     box_empty = 1'b1;

  int  snd_idle_pct = 0;
  int  rcv_idle_pct = 0;
  bit  hold_req = 1'b0;
  bit  hold_off = 1'b0;
  int  mismatches = 0;
  int  quiet_cycles = 0;

  function automatic coord_t row_dot(input row_t row, input coord_t x, input coord_t y,
                                     input coord_t z);
    longint acc, q;
    acc = longint'($signed(row[15:0])) * x + longint'($signed(row[31:16])) * y
        + longint'($signed(row[47:32])) * z + longint'($signed(row[63:48])) * 4096;
    // floor after adding half an LSB: round to nearest, ties upward
    q = (acc + 2048) >>> 12;
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    return coord_t'(q);
  endfunction

  task automatic fold_vertex(input coord_t x, input coord_t y, input coord_t z,
                             input logic is_last);
    coord_t      v[3];
    box_result_t r;
    for (int a = 0; a < 3; a++) begin
      v[a] = row_dot(mdl_rows[a], x, y, z);
      if (box_empty || v[a] < box_lo[a]) box_lo[a] = v[a];
      if (box_empty || v[a] > box_hi[a]) box_hi[a] = v[a];
    end
    box_empty = 1'b0;
    r.ox = v[0]; r.oy = v[1]; r.oz = v[2];
    r.lx = box_lo[0]; r.ly = box_lo[1]; r.lz = box_lo[2];
    r.hx = box_hi[0]; r.hy = box_hi[1]; r.hz = box_hi[2];
    r.done = is_last;
    xform_q.push_back(r);
    if (is_last) begin
      box_lo = '{0, 0, 0};
      box_hi = '{0, 0, 0};
      box_empty = 1'b1;
    end
  endtask

  function automatic void check_field(input string name, input logic signed [31:0] want,
                                      input logic signed [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Sender: advance only when the current request was taken or none is up
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) fold_vertex(coord_x, coord_y, coord_z, last_vertex);
      if (!in_valid || !in_stall) begin
        if (vertex_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          in_valid    <= 1'b1;
          coord_x     <= vertex_q[0].x;
          coord_y     <= vertex_q[0].y;
          coord_z     <= vertex_q[0].z;
          last_vertex <= vertex_q[0].is_last;
          void'(vertex_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= hold_off || ($urandom_range(99) < rcv_idle_pct);
  end

  // Long hold-off on the result side so the pipeline backs up into in_stall
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    box_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (xform_q.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, got out_x %0d",
                 $time, out_x);
        mismatches++;
      end else begin
        exp_r = xform_q.pop_front();
        check_field("out_x", exp_r.ox, out_x);
        check_field("out_y", exp_r.oy, out_y);
        check_field("out_z", exp_r.oz, out_z);
        check_field("min_x", exp_r.lx, min_x);
        check_field("min_y", exp_r.ly, min_y);
        check_field("min_z", exp_r.lz, min_z);
        check_field("max_x", exp_r.hx, max_x);
        check_field("max_y", exp_r.hy, max_y);
        check_field("max_z", exp_r.hz, max_z);
        check_field("box_done", exp_r.done, box_done);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_vertex_transform_aabb_core: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void push_vertex(input coord_t x, input coord_t y, input coord_t z,
                                      input logic is_last);
    vertex_t v;
    v.x = x; v.y = y; v.z = z; v.is_last = is_last;
    vertex_q.push_back(v);
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(9))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2, 3:    return coord_t'($urandom_range(1024) - 512);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Mostly moderate coefficients (within +-2.0), sometimes any 16-bit pattern
  function automatic row_t rand_row();
    logic [15:0] c[4];
    for (int i = 0; i < 4; i++) begin
      if ($urandom_range(3) == 0) c[i] = 16'($urandom);
      else c[i] = 16'($urandom_range(16384) - 8192);
    end
    return {c[3], c[2], c[1], c[0]};
  endfunction

  // Leaves cfg_valid up; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input row_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_ROW_X) mdl_rows[0] = data;
    else if (idx == REG_ROW_Y) mdl_rows[1] = data;
    else if (idx == REG_ROW_Z) mdl_rows[2] = data;
  endtask

  task automatic write_rows(input row_t rx, input row_t ry, input row_t rz);
    write_reg(REG_ROW_X, rx);
    write_reg(REG_ROW_Y, ry);
    write_reg(REG_ROW_Z, rz);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (vertex_q.size() != 0 || in_valid || xform_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic fill_objects(input int n, input int snd_pct, input int rcv_pct);
    int len;
    @(negedge clk);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    while (n > 0) begin
      len = $urandom_range(1, 10);
      for (int k = 0; k < len; k++)
        push_vertex(rand_coord(), rand_coord(), rand_coord(), k == len - 1);
      n -= len;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Index beyond the rows must leave the identity matrix untouched
    write_reg(REG_UNUSED, '1);
    cfg_valid <= 1'b0;

    @(negedge clk);
    snd_idle_pct = 15;
    rcv_idle_pct = 62;
    push_vertex(0, 0, 0, 1'b1);
    push_vertex(COORD_MAX, COORD_MIN, 0, 1'b0);
    push_vertex(COORD_MIN, COORD_MAX, -1, 1'b0);
    push_vertex(1, -1, COORD_MAX, 1'b0);
    push_vertex(-256, 256, COORD_MIN, 1'b1);
    // Leave this object open across the next register writes
    push_vertex(100, -100, 50, 1'b0);
    wait_drained();

    // Saturating rows on x and y; half-weight on z exercises ties
    write_rows(64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000,
               64'h0000_0000_0000_0800);
    @(negedge clk);
    push_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
    push_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    push_vertex(1, 0, 0, 1'b0);
    push_vertex(-1, 0, 0, 1'b0);
    push_vertex(3, 0, 0, 1'b0);
    push_vertex(-3, 0, 0, 1'b1);
    push_vertex(0, 0, 0, 1'b1);
    wait_drained();

    write_rows(rand_row(), '0, '1);
    fill_objects(180, 15, 62);
    wait_drained();

    write_rows(rand_row(), rand_row(), rand_row());
    fill_objects(180, 62, 15);
    wait_drained();

    write_rows('1, rand_row(), '0);
    fill_objects(190, 0, 0);
    hold_req = 1'b1;
    wait_drained();

    repeat (8) @(posedge clk);
    if (mismatches == 0 && xform_q.size() == 0) begin
      $display("tb_vertex_transform_aabb_core: PASS");
    end else begin
      $display("tb_vertex_transform_aabb_core: FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/vta_pkg.sv
rtl/vertex_transform_aabb_core.sv
tb/sv/tb_vertex_transform_aabb_core.sv
